### hw/rtl/mmau_pkg.sv
// Shared types, codes and default constants for the mapped memory access unit.
// No dependencies; the RTL files that use it refer to it by scoped names, the verification files import it.
`timescale 1ns / 1ps

package mmau_pkg;

  // Address space
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CntW      = 2;

  // Default region bounds
  localparam int unsigned RAM_TOP_DEF     = 28672;
  localparam int unsigned STACK_BASE_DEF  = 28928;
  localparam int unsigned VIDEO_BASE_DEF  = 30720;
  localparam int unsigned VIDEO_LIMIT_DEF = 32768;
  localparam int unsigned ROM_BASE_DEF    = 32768;
  localparam int unsigned SPACE_LIMIT_DEF = 65536;

  // Port address reset values
  localparam logic [AddrW-1:0] CTRL_PORT_RST   = 16'd28673;
  localparam logic [AddrW-1:0] STDIN_PORT_RST  = 16'd28674;
  localparam logic [AddrW-1:0] STDOUT_PORT_RST = 16'd28675;
  localparam logic [AddrW-1:0] STDERR_PORT_RST = 16'd28676;
  localparam logic [AddrW-1:0] STOP_PORT_RST   = 16'd28677;

  typedef enum logic [2:0] {
    REQ_READ8   = 3'd0,
    REQ_READ16  = 3'd1,
    REQ_READ32  = 3'd2,
    REQ_FETCH32 = 3'd3,
    REQ_WRITE8  = 3'd4,
    REQ_WRITE16 = 3'd5,
    REQ_ROMLOAD = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_READ   = 2'd1,
    ST_NOT_WRITE  = 2'd2,
    ST_NOT_EXEC   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_CTRL_PORT   = 3'd0,
    CFG_STDIN_PORT  = 3'd1,
    CFG_STDOUT_PORT = 3'd2,
    CFG_STDERR_PORT = 3'd3,
    CFG_STOP_PORT   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_ISSUE,
    FSM_COLLECT,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic [AddrW-1:0] ctrl;
    logic [AddrW-1:0] stdin;
    logic [AddrW-1:0] stdout;
    logic [AddrW-1:0] stderr;
    logic [AddrW-1:0] stop;
  } ports_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic collect;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mem_read;  // current byte needs a store read
    logic byte_end;  // current byte ends the transaction (fail, last or skip)
    logic byte_last; // current byte is the last one
    logic out_free;  // result register can take a new result
  } dp_stat_t;

endpackage

### hw/rtl/mmau_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mmau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mmau_cfg_regs.sv
// Port address configuration registers.
// Depends on mmau_pkg.
`timescale 1ns / 1ps

module mmau_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mmau_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mmau_pkg::AddrW-1:0]   cfg_data_i,
  output mmau_pkg::ports_t             ports_o
);

  mmau_pkg::ports_t ports_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ports_q.ctrl   <= mmau_pkg::CTRL_PORT_RST;
      ports_q.stdin  <= mmau_pkg::STDIN_PORT_RST;
      ports_q.stdout <= mmau_pkg::STDOUT_PORT_RST;
      ports_q.stderr <= mmau_pkg::STDERR_PORT_RST;
      ports_q.stop   <= mmau_pkg::STOP_PORT_RST;
    end else if (cfg_valid_i) begin
      case (mmau_pkg::cfg_idx_e'(cfg_index_i))
        mmau_pkg::CFG_CTRL_PORT:   ports_q.ctrl   <= cfg_data_i;
        mmau_pkg::CFG_STDIN_PORT:  ports_q.stdin  <= cfg_data_i;
        mmau_pkg::CFG_STDOUT_PORT: ports_q.stdout <= cfg_data_i;
        mmau_pkg::CFG_STDERR_PORT: ports_q.stderr <= cfg_data_i;
        mmau_pkg::CFG_STOP_PORT:   ports_q.stop   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ports_o = ports_q;

endmodule

### hw/rtl/mmau_ctrl.sv
// Sequencer for the memory access unit: walks the bytes of one transaction.
// Depends on mmau_pkg.
`timescale 1ns / 1ps

module mmau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mmau_pkg::dp_stat_t  stat_i,
  output mmau_pkg::dp_cmd_t   cmd_o
);

  mmau_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmau_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mmau_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mmau_pkg::FSM_ISSUE;
        end
      end
      mmau_pkg::FSM_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (stat_i.mem_read) begin
          state_d = mmau_pkg::FSM_COLLECT;
        end else if (stat_i.byte_end) begin
          state_d = mmau_pkg::FSM_FINISH;
        end
      end
      mmau_pkg::FSM_COLLECT: begin
        cmd_o.collect = 1'b1;
        state_d = stat_i.byte_last ? mmau_pkg::FSM_FINISH : mmau_pkg::FSM_ISSUE;
      end
      mmau_pkg::FSM_FINISH: begin
        // hold until the result register frees up
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = mmau_pkg::FSM_IDLE;
        end
      end
    endcase
  end

endmodule

### hw/rtl/mmau_datapath.sv
// Datapath of the memory access unit: region checks, port decode, byte store,
// read assembly and result register. Depends on mmau_pkg and mmau_ram.
`timescale 1ns / 1ps

module mmau_datapath #(
  parameter int unsigned RAM_TOP     = mmau_pkg::RAM_TOP_DEF,
  parameter int unsigned STACK_BASE  = mmau_pkg::STACK_BASE_DEF,
  parameter int unsigned VIDEO_BASE  = mmau_pkg::VIDEO_BASE_DEF,
  parameter int unsigned VIDEO_LIMIT = mmau_pkg::VIDEO_LIMIT_DEF,
  parameter int unsigned ROM_BASE    = mmau_pkg::ROM_BASE_DEF,
  parameter int unsigned SPACE_LIMIT = mmau_pkg::SPACE_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmau_pkg::dp_cmd_t           cmd_i,
  output mmau_pkg::dp_stat_t          stat_o,
  input  mmau_pkg::ports_t            ports_i,
  input  logic [2:0]                  req_type_i,
  input  logic [mmau_pkg::AddrW-1:0]  address_i,
  input  logic [15:0]                 write_data_i,
  input  logic [mmau_pkg::ByteW-1:0]  controller_state_i,
  input  logic [mmau_pkg::ByteW-1:0]  stdin_char_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mmau_pkg::WordW-1:0]  read_data_o,
  output logic [1:0]                  status_o,
  output logic                        misaligned_o,
  output logic                        stdout_valid_o,
  output logic [mmau_pkg::ByteW-1:0]  stdout_char_o,
  output logic                        stderr_valid_o,
  output logic [mmau_pkg::ByteW-1:0]  stderr_char_o,
  output logic                        stop_request_o,
  output logic                        stdin_taken_o
);

  localparam int unsigned AW = mmau_pkg::AddrW;
  localparam int unsigned BW = mmau_pkg::ByteW;
  localparam int unsigned CW = mmau_pkg::CntW;

  localparam logic [AW:0] RamTopX     = (AW+1)'(RAM_TOP);
  localparam logic [AW:0] StackBaseX  = (AW+1)'(STACK_BASE);
  localparam logic [AW:0] VideoBaseX  = (AW+1)'(VIDEO_BASE);
  localparam logic [AW:0] VideoLimitX = (AW+1)'(VIDEO_LIMIT);
  localparam logic [AW:0] RomBaseX    = (AW+1)'(ROM_BASE);
  localparam logic [AW:0] SpaceLimitX = (AW+1)'(SPACE_LIMIT);

  // Working registers for the transaction in flight
  logic [2:0]               req_q;
  logic [AW-1:0]            addr_q;
  logic [15:0]              data_q;
  logic [BW-1:0]            ctrl_q;
  logic [BW-1:0]            stdin_q;
  logic [CW-1:0]            cnt_q;
  logic [mmau_pkg::WordW-1:0] acc_q;
  mmau_pkg::status_e        status_q;
  logic                     mis_q;
  logic                     so_v_q, se_v_q, stop_q, taken_q;
  logic [BW-1:0]            so_c_q, se_c_q;

  // Result register
  logic                     out_valid_q;
  logic [mmau_pkg::WordW-1:0] out_rd_q;
  logic [1:0]               out_st_q;
  logic                     out_mis_q, out_so_v_q, out_se_v_q, out_stop_q, out_taken_q;
  logic [BW-1:0]            out_so_c_q, out_se_c_q;

  logic [AW-1:0] ba;
  logic [AW:0]   bax;
  logic          rd_ok, wr_ok;
  logic          hit_ctrl, hit_stdin, hit_out, hit_err, hit_stop;
  logic          is_read, is_write, is_rom, skip, last;
  logic [BW-1:0] wbyte;
  logic          byte_fail, mem_read, ram_we;
  logic [BW-1:0] ram_rdata;
  logic          in_odd, in_exec;

  function automatic logic exec_ok(logic [AW:0] a);
    return (a >= RomBaseX) && (a < SpaceLimitX);
  endfunction

  // Byte address wraps at the top of the space
  assign ba  = addr_q + AW'(cnt_q);
  assign bax = {1'b0, ba};

  assign hit_ctrl  = (ba == ports_i.ctrl);
  assign hit_stdin = (ba == ports_i.stdin);
  assign hit_out   = (ba == ports_i.stdout);
  assign hit_err   = (ba == ports_i.stderr);
  assign hit_stop  = (ba == ports_i.stop);

  assign rd_ok = (bax <= RamTopX) ||
                 ((bax >= StackBaseX) && (bax < VideoBaseX)) ||
                 ((bax >= VideoBaseX) && (bax < VideoLimitX)) ||
                 hit_ctrl || hit_stdin || exec_ok(bax);
  assign wr_ok = (bax <= RamTopX) ||
                 ((bax >= StackBaseX) && (bax < VideoBaseX)) ||
                 ((bax >= VideoBaseX) && (bax < VideoLimitX)) ||
                 hit_out || hit_err || hit_stop;

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_rom   = 1'b0;
    last     = 1'b1;
    case (mmau_pkg::req_e'(req_q))
      mmau_pkg::REQ_READ8:   is_read = 1'b1;
      mmau_pkg::REQ_READ16:  begin is_read = 1'b1; last = (cnt_q == CW'(1)); end
      mmau_pkg::REQ_READ32:  begin is_read = 1'b1; last = (cnt_q == CW'(3)); end
      mmau_pkg::REQ_FETCH32: begin is_read = 1'b1; last = (cnt_q == CW'(3)); end
      mmau_pkg::REQ_WRITE8:  is_write = 1'b1;
      mmau_pkg::REQ_WRITE16: begin is_write = 1'b1; last = (cnt_q == CW'(1)); end
      mmau_pkg::REQ_ROMLOAD: is_rom = 1'b1;
      default: ;
    endcase
  end

  // Only a failed fetch check can leave a nonzero status before the first byte
  assign skip = !(is_read || is_write || is_rom) || (status_q != mmau_pkg::ST_OK);

  assign wbyte = ((mmau_pkg::req_e'(req_q) == mmau_pkg::REQ_WRITE16) && (cnt_q == '0)) ?
                 data_q[15:8] : data_q[7:0];

  assign byte_fail = !skip && ((is_read && !rd_ok) || (is_write && !wr_ok));
  assign mem_read  = !skip && is_read && rd_ok && !hit_ctrl && !hit_stdin;
  assign ram_we    = cmd_i.issue && !skip &&
                     ((is_write && wr_ok && !hit_out && !hit_err && !hit_stop) || is_rom);

  assign stat_o.mem_read  = mem_read;
  assign stat_o.byte_end  = skip || byte_fail || last;
  assign stat_o.byte_last = last;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  mmau_ram #(
    .WIDTH(BW),
    .DEPTH(mmau_pkg::StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ba),
    .wdata_i(wbyte),
    .rdata_o(ram_rdata)
  );

  assign in_odd  = address_i[0];
  assign in_exec = exec_ok({1'b0, address_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      addr_q   <= address_i;
      data_q   <= write_data_i;
      ctrl_q   <= controller_state_i;
      stdin_q  <= stdin_char_i;
      cnt_q    <= '0;
      acc_q    <= '0;
      so_v_q   <= 1'b0;
      se_v_q   <= 1'b0;
      so_c_q   <= '0;
      se_c_q   <= '0;
      stop_q   <= 1'b0;
      taken_q  <= 1'b0;
      status_q <= mmau_pkg::ST_OK;
      mis_q    <= 1'b0;
      case (mmau_pkg::req_e'(req_type_i))
        mmau_pkg::REQ_READ16, mmau_pkg::REQ_READ32, mmau_pkg::REQ_WRITE16: begin
          mis_q <= in_odd;
        end
        mmau_pkg::REQ_FETCH32: begin
          if (in_exec) begin
            mis_q <= in_odd;
          end else begin
            status_q <= mmau_pkg::ST_NOT_EXEC;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.issue) begin
      if (!mem_read) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (!skip && is_read) begin
        priority if (!rd_ok) begin
          status_q <= mmau_pkg::ST_NOT_READ;
        end else if (hit_ctrl) begin
          acc_q <= {acc_q[mmau_pkg::WordW-BW-1:0], ctrl_q};
        end else if (hit_stdin) begin
          acc_q   <= {acc_q[mmau_pkg::WordW-BW-1:0], stdin_q};
          taken_q <= 1'b1;
        end else begin
          // store byte arrives in the collect cycle
        end
      end
      if (!skip && is_write) begin
        priority if (!wr_ok) begin
          status_q <= mmau_pkg::ST_NOT_WRITE;
        end else if (hit_out) begin
          so_v_q <= 1'b1;
          so_c_q <= wbyte;
        end else if (hit_err) begin
          se_v_q <= 1'b1;
          se_c_q <= wbyte;
        end else if (hit_stop) begin
          stop_q <= 1'b1;
        end else begin
          // store write
        end
      end
    end else if (cmd_i.collect) begin
      cnt_q <= cnt_q + CW'(1);
      acc_q <= {acc_q[mmau_pkg::WordW-BW-1:0], ram_rdata};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_rd_q    <= (status_q == mmau_pkg::ST_OK) ? acc_q : '0;
      out_st_q    <= status_q;
      out_mis_q   <= mis_q;
      out_so_v_q  <= so_v_q;
      out_so_c_q  <= so_c_q;
      out_se_v_q  <= se_v_q;
      out_se_c_q  <= se_c_q;
      out_stop_q  <= stop_q;
      out_taken_q <= taken_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign status_o       = out_st_q;
  assign misaligned_o   = out_mis_q;
  assign stdout_valid_o = out_so_v_q;
  assign stdout_char_o  = out_so_c_q;
  assign stderr_valid_o = out_se_v_q;
  assign stderr_char_o  = out_se_c_q;
  assign stop_request_o = out_stop_q;
  assign stdin_taken_o  = out_taken_q;

endmodule

### hw/rtl/mapped_memory_access_unit.sv
// A transaction is loaded, then each byte gets an issue step (a store read adds a
// collect step), and a finish step loads the result register and raises out_valid_o; a
// request with no byte (failed fetch, unused code) still passes through issue before
// finish. Finish waits while an unread result holds that register; a finished result waits
// in its own register, so the next transaction is taken while the previous one is unread.
// Reset clears the control state and loads the default port addresses, not the store.
`timescale 1ns / 1ps

module mapped_memory_access_unit #(
  parameter int unsigned RAM_TOP     = mmau_pkg::RAM_TOP_DEF,
  parameter int unsigned STACK_BASE  = mmau_pkg::STACK_BASE_DEF,
  parameter int unsigned VIDEO_BASE  = mmau_pkg::VIDEO_BASE_DEF,
  parameter int unsigned VIDEO_LIMIT = mmau_pkg::VIDEO_LIMIT_DEF,
  parameter int unsigned ROM_BASE    = mmau_pkg::ROM_BASE_DEF,
  parameter int unsigned SPACE_LIMIT = mmau_pkg::SPACE_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mmau_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mmau_pkg::AddrW-1:0]   cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   req_type_i,
  input  logic [mmau_pkg::AddrW-1:0]   address_i,
  input  logic [15:0]                  write_data_i,
  input  logic [mmau_pkg::ByteW-1:0]   controller_state_i,
  input  logic [mmau_pkg::ByteW-1:0]   stdin_char_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mmau_pkg::WordW-1:0]   read_data_o,
  output logic [1:0]                   status_o,
  output logic                         misaligned_o,
  output logic                         stdout_valid_o,
  output logic [mmau_pkg::ByteW-1:0]   stdout_char_o,
  output logic                         stderr_valid_o,
  output logic [mmau_pkg::ByteW-1:0]   stderr_char_o,
  output logic                         stop_request_o,
  output logic                         stdin_taken_o
);

  mmau_pkg::ports_t   ports;
  mmau_pkg::dp_cmd_t  cmd;
  mmau_pkg::dp_stat_t stat;

  // Port addresses; writes land whenever offered, the block is idle by contract
  mmau_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ports_o    (ports)
  );

  // Sequencer: load, then one issue (plus a collect for store reads) per byte,
  // then hand the result to the output register
  mmau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Region checks, port decode, byte store and result register
  mmau_datapath #(
    .RAM_TOP    (RAM_TOP),
    .STACK_BASE (STACK_BASE),
    .VIDEO_BASE (VIDEO_BASE),
    .VIDEO_LIMIT(VIDEO_LIMIT),
    .ROM_BASE   (ROM_BASE),
    .SPACE_LIMIT(SPACE_LIMIT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .ports_i           (ports),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .controller_state_i(controller_state_i),
    .stdin_char_i      (stdin_char_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .status_o          (status_o),
    .misaligned_o      (misaligned_o),
    .stdout_valid_o    (stdout_valid_o),
    .stdout_char_o     (stdout_char_o),
    .stderr_valid_o    (stderr_valid_o),
    .stderr_char_o     (stderr_char_o),
    .stop_request_o    (stop_request_o),
    .stdin_taken_o     (stdin_taken_o)
  );

endmodule

### verif/mmau_access_checker_pkg.sv
// Request and result types plus the access checker class for the mapped memory
// access unit testbench. Depends on mmau_pkg for codes, widths and region bounds.
`timescale 1ns / 1ps

package mmau_access_checker_pkg;
  import mmau_pkg::*;

  // request code with no operation behind it
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [7:0]  ctrl_state;
    logic [7:0]  stdin_char;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic        misaligned;
    logic        stdout_valid;
    logic [7:0]  stdout_char;
    logic        stderr_valid;
    logic [7:0]  stderr_char;
    logic        stop_request;
    logic        stdin_taken;
  } mem_rsp_t;

  typedef logic [15:0] addr_q_t [$];

  class access_checker;
    logic [7:0]  store_bytes [StoreDepth];
    bit          written [StoreDepth];
    logic [15:0] port_addr [5];
    mem_rsp_t    answers [$];
    int unsigned errors;

    function new();
      port_addr[CFG_CTRL_PORT]   = CTRL_PORT_RST;
      port_addr[CFG_STDIN_PORT]  = STDIN_PORT_RST;
      port_addr[CFG_STDOUT_PORT] = STDOUT_PORT_RST;
      port_addr[CFG_STDERR_PORT] = STDERR_PORT_RST;
      port_addr[CFG_STOP_PORT]   = STOP_PORT_RST;
      errors = 0;
    endfunction

    function void set_port(cfg_idx_e idx, logic [15:0] value);
      port_addr[idx] = value;
    endfunction

    function bit readable(logic [15:0] a);
      return a <= RAM_TOP_DEF || (a >= STACK_BASE_DEF && a < VIDEO_LIMIT_DEF) ||
             a == port_addr[CFG_CTRL_PORT] || a == port_addr[CFG_STDIN_PORT] ||
             (a >= ROM_BASE_DEF && a < SPACE_LIMIT_DEF);
    endfunction

    function bit writable(logic [15:0] a);
      return a <= RAM_TOP_DEF || (a >= STACK_BASE_DEF && a < VIDEO_LIMIT_DEF) ||
             a == port_addr[CFG_STDOUT_PORT] || a == port_addr[CFG_STDERR_PORT] ||
             a == port_addr[CFG_STOP_PORT];
    endfunction

    function bit executable(logic [15:0] a);
      return a >= ROM_BASE_DEF && a < SPACE_LIMIT_DEF;
    endfunction

    // bytes a request tries to read; a fetch outside ROM reads none
    function int unsigned read_len(mem_req_t r);
      case (r.req)
        REQ_READ8:   return 1;
        REQ_READ16:  return 2;
        REQ_READ32:  return 4;
        REQ_FETCH32: return executable(r.addr) ? 4 : 0;
        default:     return 0;
      endcase
    endfunction

    // store bytes the request would read that were never written
    function addr_q_t unwritten_reads(mem_req_t r);
      addr_q_t     miss;
      logic [15:0] a;
      for (int i = 0; i < read_len(r); i++) begin
        a = r.addr + 16'(i);
        if (!readable(a)) return miss;
        if (a != port_addr[CFG_CTRL_PORT] && a != port_addr[CFG_STDIN_PORT] && !written[a])
          miss.push_back(a);
      end
      return miss;
    endfunction

    function bit read_byte(logic [15:0] a, mem_req_t r, inout mem_rsp_t rsp,
                           output logic [7:0] v);
      v = '0;
      if (!readable(a)) begin
        rsp.status = ST_NOT_READ;
        return 1'b0;
      end
      if (a == port_addr[CFG_CTRL_PORT]) begin
        v = r.ctrl_state;
      end else if (a == port_addr[CFG_STDIN_PORT]) begin
        v = r.stdin_char;
        rsp.stdin_taken = 1'b1;
      end else begin
        v = store_bytes[a];
      end
      return 1'b1;
    endfunction

    function bit write_byte(logic [15:0] a, logic [7:0] v, inout mem_rsp_t rsp);
      if (!writable(a)) begin
        rsp.status = ST_NOT_WRITE;
        return 1'b0;
      end
      if (a == port_addr[CFG_STDOUT_PORT]) begin
        rsp.stdout_valid = 1'b1;
        rsp.stdout_char  = v;
      end else if (a == port_addr[CFG_STDERR_PORT]) begin
        rsp.stderr_valid = 1'b1;
        rsp.stderr_char  = v;
      end else if (a == port_addr[CFG_STOP_PORT]) begin
        rsp.stop_request = 1'b1;
      end else begin
        store_bytes[a] = v;
        written[a]     = 1'b1;
      end
      return 1'b1;
    endfunction

    function mem_rsp_t model_access(mem_req_t r);
      mem_rsp_t    rsp;
      logic [7:0]  b;
      bit          ok;
      rsp = '0;
      ok  = 1'b1;
      case (r.req)
        REQ_READ16, REQ_READ32: rsp.misaligned = r.addr[0];
        REQ_FETCH32: begin
          if (!executable(r.addr)) rsp.status = ST_NOT_EXEC;
          else rsp.misaligned = r.addr[0];
        end
        REQ_WRITE8: void'(write_byte(r.addr, r.wdata[7:0], rsp));
        REQ_WRITE16: begin
          rsp.misaligned = r.addr[0];
          // the high byte stays written even when the low byte fails
          if (write_byte(r.addr, r.wdata[15:8], rsp))
            void'(write_byte(r.addr + 16'd1, r.wdata[7:0], rsp));
        end
        REQ_ROMLOAD: begin
          store_bytes[r.addr] = r.wdata[7:0];
          written[r.addr]     = 1'b1;
        end
        default: ;
      endcase
      for (int i = 0; i < read_len(r) && ok; i++) begin
        ok = read_byte(r.addr + 16'(i), r, rsp, b);
        rsp.read_data = ok ? {rsp.read_data[23:0], b} : 32'd0;
      end
      return rsp;
    endfunction

    function void note_request(mem_req_t r);
      answers.push_back(model_access(r));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(mem_rsp_t got);
      mem_rsp_t want;
      if (answers.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: expected none, actual %h", $time, got);
        return;
      end
      want = answers.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("status", want.status, got.status);
      compare_field("misaligned", want.misaligned, got.misaligned);
      compare_field("stdout_valid", want.stdout_valid, got.stdout_valid);
      compare_field("stdout_char", want.stdout_char, got.stdout_char);
      compare_field("stderr_valid", want.stderr_valid, got.stderr_valid);
      compare_field("stderr_char", want.stderr_char, got.stderr_char);
      compare_field("stop_request", want.stop_request, got.stop_request);
      compare_field("stdin_taken", want.stdin_taken, got.stdin_taken);
    endfunction
  endclass

endpackage

### verif/mapped_memory_access_unit_test.sv
// Top-level testbench for mapped_memory_access_unit: drives requests and port
// settings, checks every result against the access checker in the package.
// Depends on mmau_pkg and mmau_access_checker_pkg.
`timescale 1ns / 1ps

module mapped_memory_access_unit_test;
  import mmau_pkg::*;
  import mmau_access_checker_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  // the slowest transaction is a read32 from the store
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned NumBoundary = 15;
  localparam logic [15:0] BOUNDARY_ADDRS [NumBoundary] = '{
    16'd0, 16'd1, 16'd28671, 16'd28672, 16'd28673, 16'd28927, 16'd28928, 16'd30719,
    16'd30720, 16'd32766, 16'd32767, 16'd32768, 16'd32769, 16'd65534, 16'd65535
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] write_data_i = '0;
  logic [7:0]  controller_state_i = '0;
  logic [7:0]  stdin_char_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic [1:0]  status_o;
  logic        misaligned_o;
  logic        stdout_valid_o;
  logic [7:0]  stdout_char_o;
  logic        stderr_valid_o;
  logic [7:0]  stderr_char_o;
  logic        stop_request_o;
  logic        stdin_taken_o;

  access_checker chk;
  bit            calm = 1'b0;      // no idling on either side while set
  int unsigned   hold_left = 0;    // cycles the result side still holds off
  int unsigned   cycle_count = 0;
  int unsigned   sent_n = 0;       // request transactions accepted so far
  logic [15:0]   recent_addr [$];  // targets of recent writes, for read-back

  mapped_memory_access_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .address_i          (address_i),
    .write_data_i       (write_data_i),
    .controller_state_i (controller_state_i),
    .stdin_char_i       (stdin_char_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .read_data_o        (read_data_o),
    .status_o           (status_o),
    .misaligned_o       (misaligned_o),
    .stdout_valid_o     (stdout_valid_o),
    .stdout_char_o      (stdout_char_o),
    .stderr_valid_o     (stderr_valid_o),
    .stderr_char_o      (stderr_char_o),
    .stop_request_o     (stop_request_o),
    .stdin_taken_o      (stdin_taken_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL mapped_memory_access_unit");
      $finish;
    end
  end

  // Check every result transaction against the oldest outstanding answer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      chk.check_result('{read_data: read_data_o, status: status_o, misaligned: misaligned_o,
                         stdout_valid: stdout_valid_o, stdout_char: stdout_char_o,
                         stderr_valid: stderr_valid_o, stderr_char: stderr_char_o,
                         stop_request: stop_request_o, stdin_taken: stdin_taken_o});
    end
  end

  // Result side: hold off for a counted stretch when asked, else stall at random
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 32);
    end
  end

  function automatic mem_req_t make_req(logic [2:0] req, logic [15:0] addr,
                                        logic [15:0] wdata);
    mem_req_t r;
    r.req        = req;
    r.addr       = addr;
    r.wdata      = wdata;
    r.ctrl_state = 8'($urandom);
    r.stdin_char = 8'($urandom);
    return r;
  endfunction

  // Aim at region edges, ports, recent writes and each region in turn
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(9))
      0: return BOUNDARY_ADDRS[$urandom_range(NumBoundary - 1)];
      1, 2: return chk.port_addr[$urandom_range(4)] + 16'($urandom_range(4)) - 16'd2;
      3: begin
        if (recent_addr.size() != 0) return recent_addr[$urandom_range(recent_addr.size() - 1)];
        else return 16'($urandom);
      end
      4: return 16'($urandom_range(RAM_TOP_DEF));
      5: return 16'($urandom_range(VIDEO_LIMIT_DEF - 1, STACK_BASE_DEF));
      6: return 16'($urandom_range(SPACE_LIMIT_DEF - 1, ROM_BASE_DEF));
      7: return 16'($urandom_range(STACK_BASE_DEF - 1, RAM_TOP_DEF + 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mem_req_t random_req();
    int unsigned pick;
    logic [2:0]  req;
    pick = $urandom_range(99);
    if (pick < 15) req = REQ_READ8;
    else if (pick < 28) req = REQ_READ16;
    else if (pick < 41) req = REQ_READ32;
    else if (pick < 52) req = REQ_FETCH32;
    else if (pick < 67) req = REQ_WRITE8;
    else if (pick < 82) req = REQ_WRITE16;
    else if (pick < 97) req = REQ_ROMLOAD;
    else req = REQ_UNUSED;
    return make_req(req, pick_addr(), 16'($urandom));
  endfunction

  // Enter and leave at a falling edge; valid stays up for the next caller to
  // drop or reuse, so it never gets two assignments in one step.
  task automatic send(input mem_req_t r);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= r.req;
    address_i          <= r.addr;
    write_data_i       <= r.wdata;
    controller_state_i <= r.ctrl_state;
    stdin_char_i       <= r.stdin_char;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chk.note_request(r);
    sent_n++;
    @(negedge clk_i);
  endtask

  // Load every store byte the request would read but that was never written
  task automatic issue(input mem_req_t r);
    addr_q_t miss;
    miss = chk.unwritten_reads(r);
    foreach (miss[k]) send(make_req(REQ_ROMLOAD, miss[k], 16'($urandom)));
    send(r);
    if (r.req == REQ_WRITE8 || r.req == REQ_WRITE16 || r.req == REQ_ROMLOAD) begin
      recent_addr.push_back(r.addr);
      if (recent_addr.size() > 32) void'(recent_addr.pop_front());
    end
  endtask

  // Pause the request side until every outstanding answer has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (chk.answers.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_port(input cfg_idx_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    chk.set_port(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_ports(input logic [15:0] ctrl, input logic [15:0] stdin_p,
                           input logic [15:0] stdout_p, input logic [15:0] stderr_p,
                           input logic [15:0] stop_p);
    drain();
    write_port(CFG_CTRL_PORT, ctrl);
    write_port(CFG_STDIN_PORT, stdin_p);
    write_port(CFG_STDOUT_PORT, stdout_p);
    write_port(CFG_STDERR_PORT, stderr_p);
    write_port(CFG_STOP_PORT, stop_p);
  endtask

  // Mostly single random requests; a quarter are a write followed by a read
  // of the same address so stored data is seen again. The count covers the
  // loads of unwritten bytes too.
  task automatic run_random(input int unsigned count);
    int unsigned start_n;
    mem_req_t    r;
    logic [2:0]  rd_kind;
    start_n = sent_n;
    while (sent_n - start_n < count) begin
      r = random_req();
      if ($urandom_range(3) == 0) begin
        r.req = ($urandom_range(2) == 0) ? REQ_WRITE8 :
                ($urandom_range(1) == 0) ? REQ_WRITE16 : REQ_ROMLOAD;
        issue(r);
        case ($urandom_range(3))
          0: rd_kind = REQ_READ8;
          1: rd_kind = REQ_READ16;
          2: rd_kind = REQ_READ32;
          default: rd_kind = REQ_FETCH32;
        endcase
        issue(make_req(rd_kind, r.addr, 16'($urandom)));
      end else begin
        issue(r);
      end
    end
  endtask

  initial begin
    chk = new();
    // hold reset low from the start, release at a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with port addresses at their reset values
    issue(make_req(REQ_ROMLOAD, 16'd0, 16'h00FF));
    issue(make_req(REQ_ROMLOAD, 16'hFFFF, 16'hFF5A));
    issue(make_req(REQ_READ8, 16'd0, 16'd0));
    issue(make_req(REQ_READ8, 16'hFFFF, 16'd0));
    // multi-byte reads that wrap past the top of the space
    issue(make_req(REQ_READ16, 16'hFFFF, 16'd0));
    issue(make_req(REQ_READ32, 16'hFFFE, 16'd0));
    issue(make_req(REQ_FETCH32, 16'(ROM_BASE_DEF), 16'd0));
    issue(make_req(REQ_FETCH32, 16'(ROM_BASE_DEF + 1), 16'd0));
    // fetches outside ROM, one of them at a port
    issue(make_req(REQ_FETCH32, 16'd0, 16'd0));
    issue(make_req(REQ_FETCH32, CTRL_PORT_RST, 16'd0));
    // controller before stdin, and a read that consumes stdin then fails
    issue(make_req(REQ_READ8, CTRL_PORT_RST, 16'd0));
    issue(make_req(REQ_READ8, STDIN_PORT_RST, 16'd0));
    issue(make_req(REQ_READ16, CTRL_PORT_RST, 16'd0));
    issue(make_req(REQ_READ8, 16'd28680, 16'd0));
    issue(make_req(REQ_READ32, STDIN_PORT_RST, 16'd0));
    issue(make_req(REQ_READ32, 16'(RAM_TOP_DEF - 2), 16'd0));
    // port writes and writes outside the writable regions
    issue(make_req(REQ_WRITE8, STDOUT_PORT_RST, 16'hFFFF));
    issue(make_req(REQ_WRITE8, STDERR_PORT_RST, 16'h0000));
    issue(make_req(REQ_WRITE8, STOP_PORT_RST, 16'h00A5));
    issue(make_req(REQ_WRITE8, 16'd28680, 16'h0011));
    issue(make_req(REQ_WRITE8, 16'(ROM_BASE_DEF), 16'h0022));
    issue(make_req(REQ_WRITE16, STDOUT_PORT_RST, 16'hA55A));
    // second byte fails; the first byte must stick
    issue(make_req(REQ_WRITE16, 16'(RAM_TOP_DEF), 16'hC3E1));
    issue(make_req(REQ_READ8, 16'(RAM_TOP_DEF), 16'd0));
    issue(make_req(REQ_WRITE16, 16'(VIDEO_LIMIT_DEF - 1), 16'h1234));
    issue(make_req(REQ_WRITE16, 16'hFFFF, 16'h5678));
    issue(make_req(REQ_WRITE16, 16'(STACK_BASE_DEF), 16'hFFFF));
    issue(make_req(REQ_READ16, 16'(STACK_BASE_DEF), 16'd0));
    issue(make_req(REQ_UNUSED, 16'($urandom), 16'($urandom)));

    // Stall the result side for a long stretch while requests keep coming
    hold_left = HoldCycles;
    run_random(200);

    // All ports on one address: port priority on reads and on writes
    set_ports(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;

    set_ports(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150);

    set_ports(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(250);

    // ports spread over the unmapped gap above RAM
    set_ports(16'($urandom_range(STACK_BASE_DEF - 1, RAM_TOP_DEF + 1)),
              16'($urandom_range(STACK_BASE_DEF - 1, RAM_TOP_DEF + 1)),
              16'($urandom_range(STACK_BASE_DEF - 1, RAM_TOP_DEF + 1)),
              16'($urandom_range(STACK_BASE_DEF - 1, RAM_TOP_DEF + 1)),
              16'($urandom_range(STACK_BASE_DEF - 1, RAM_TOP_DEF + 1)));
    run_random(250);

    drain();
    if (chk.errors == 0) begin
      $display("PASS mapped_memory_access_unit");
    end else begin
      $display("FAIL mapped_memory_access_unit");
    end
    $finish;
  end

endmodule

### mapped_memory_access_unit.f
hw/rtl/mmau_pkg.sv
hw/rtl/mmau_ram.sv
hw/rtl/mmau_cfg_regs.sv
hw/rtl/mmau_ctrl.sv
hw/rtl/mmau_datapath.sv
hw/rtl/mapped_memory_access_unit.sv
verif/mmau_access_checker_pkg.sv
verif/mapped_memory_access_unit_test.sv
